@@ rtl/mouse_position_event_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Mouse position event filter: assertion macros
// Concurrent checks are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOUSE_POSITION_EVENT_FILTER_ASSERT_SVH
`define MOUSE_POSITION_EVENT_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define MPEF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MPEF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPEF_ASSERT(label, prop, msg)
`define MPEF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/mpef_pkg.sv @@
// ----------------------------------------------------------------------------
// Mouse position event filter: shared package
// Widths, register indexes, function codes, event type and clamp helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mpef_pkg;

    // event queue depth and derived widths
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // field widths
    localparam int POS_W   = 15;
    localparam int DELTA_W = 16;
    localparam int BTN_W   = 8;
    localparam int WHL_W   = 8;
    localparam int SUM_W   = 18;   // position plus signed delta, with sign
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 15;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_EN_RELEASE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_EN_DRAG       = 3'd3;
    localparam logic [IDX_W-1:0] REG_EN_MOVE       = 3'd4;

    // register reset values
    localparam logic [POS_W-1:0] SCREEN_WIDTH_RST  = 15'd320;
    localparam logic [POS_W-1:0] SCREEN_HEIGHT_RST = 15'd240;

    // function codes
    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic        [BTN_W-1:0] buttons;
        logic        [BTN_W-1:0] toggled;
        logic signed [WHL_W-1:0] wheel;
        logic signed [WHL_W-1:0] pan;
        logic        [POS_W-1:0] x;
        logic        [POS_W-1:0] y;
    } ev_t;

    typedef struct packed {
        logic             from_fifo;
        ev_t              ev;
        logic [CNT_W-1:0] left;
    } res_t;

    // add a signed delta and clamp to 0 .. extent-1 (extent 0 acts as 1)
    function automatic logic [POS_W-1:0] clamp_pos(
        input logic        [POS_W-1:0]   pos,
        input logic signed [DELTA_W-1:0] delta,
        input logic        [POS_W-1:0]   extent
    );
        logic        [POS_W-1:0] lim;
        logic signed [SUM_W-1:0] v;
        lim = (extent == '0) ? '0 : extent - 1'b1;
        v   = $signed({{(SUM_W - POS_W){1'b0}}, pos})
            + $signed({{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta});
        if (v[SUM_W-1])
            return '0;
        else if (v[SUM_W-2:0] > {{(SUM_W - 1 - POS_W){1'b0}}, lim})
            return lim;
        else
            return v[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/mouse_position_event_filter.sv @@
// ----------------------------------------------------------------------------
// Mouse position event filter
// Tracks a clamped pointer position from mouse reports and queues filtered
// button, drag, move and wheel events in a small drop-oldest queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): func selects a mouse report or a read.
//   A report updates position and button state and may queue an event; it
//   produces no result. A read pops the oldest queued event, or returns a
//   snapshot of the current state when the queue is empty.
//   Output channel (out_valid/out_ready): one result per read, registered in
//   the output stage. Throughput is one item per cycle while the skid stage is
//   empty, set by the combinational update of position, button and queue state.
//   A full queue drops its oldest entry on a push.
//   Configuration channel (cfg_valid/cfg_ready): always ready; write only
//   while idle. Indexes beyond the register list are ignored.
//   When the receiver stalls, one further result is held in a skid stage and
//   in_ready drops until that stage drains.
//   Reset: screen 320 x 240, release and drag events on, move events off,
//   position and buttons zero, queue empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mouse_position_event_filter_assert.svh"

module mouse_position_event_filter (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [mpef_pkg::IDX_W-1:0]             cfg_index,
    input  wire logic [mpef_pkg::DATA_W-1:0]            cfg_data,
    // input items
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   func,
    input  wire logic [mpef_pkg::BTN_W-1:0]             button_bits,
    input  wire logic signed [mpef_pkg::DELTA_W-1:0]    delta_x,
    input  wire logic signed [mpef_pkg::DELTA_W-1:0]    delta_y,
    input  wire logic signed [mpef_pkg::WHL_W-1:0]      wheel_delta,
    input  wire logic signed [mpef_pkg::WHL_W-1:0]      pan_delta,
    // results
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        from_fifo,
    output logic [mpef_pkg::BTN_W-1:0]                  ev_buttons,
    output logic [mpef_pkg::BTN_W-1:0]                  ev_toggled,
    output logic signed [mpef_pkg::WHL_W-1:0]           ev_wheel,
    output logic signed [mpef_pkg::WHL_W-1:0]           ev_pan,
    output logic [mpef_pkg::POS_W-1:0]                  ev_x,
    output logic [mpef_pkg::POS_W-1:0]                  ev_y,
    output logic [mpef_pkg::CNT_W-1:0]                  events_left
);

    localparam logic [mpef_pkg::PTR_W-1:0] LAST_PTR =
        mpef_pkg::PTR_W'(mpef_pkg::FIFO_DEPTH - 1);
    localparam logic [mpef_pkg::CNT_W-1:0] FULL_CNT =
        mpef_pkg::CNT_W'(mpef_pkg::FIFO_DEPTH);
    localparam int TAIL_W = mpef_pkg::PTR_W + 1;
    localparam logic [TAIL_W-1:0] DEPTH_TAIL = TAIL_W'(mpef_pkg::FIFO_DEPTH);

    // configuration registers
    logic [mpef_pkg::POS_W-1:0] width_reg;
    logic [mpef_pkg::POS_W-1:0] height_reg;
    logic                       en_release_reg;
    logic                       en_drag_reg;
    logic                       en_move_reg;

    // tracker state
    logic [mpef_pkg::BTN_W-1:0] prev_buttons_reg, prev_buttons_next;
    logic [mpef_pkg::POS_W-1:0] pos_x_reg, pos_x_next;
    logic [mpef_pkg::POS_W-1:0] pos_y_reg, pos_y_next;

    // event queue
    mpef_pkg::ev_t              fifo_reg [mpef_pkg::FIFO_DEPTH];
    logic [mpef_pkg::PTR_W-1:0] head_reg, head_next;
    logic [mpef_pkg::CNT_W-1:0] count_reg, count_next;

    // output stage and skid stage
    logic                       out_valid_reg;
    mpef_pkg::res_t             out_res_reg;
    logic                       skid_valid_reg;
    mpef_pkg::res_t             skid_res_reg;

    logic                       in_xfer;
    logic                       is_report;
    logic                       is_read;
    logic                       out_free;
    mpef_pkg::ev_t              new_ev;
    logic                       queue_it;
    logic                       push;
    logic [mpef_pkg::PTR_W-1:0] head_inc;
    logic [TAIL_W-1:0]          tail_sum;
    logic [mpef_pkg::PTR_W-1:0] tail_ptr;
    mpef_pkg::res_t             res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign is_report = in_xfer && (func == mpef_pkg::FUNC_REPORT);
    assign is_read   = in_xfer && (func == mpef_pkg::FUNC_READ);
    assign out_free  = !out_valid_reg || out_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= mpef_pkg::SCREEN_WIDTH_RST;
            height_reg     <= mpef_pkg::SCREEN_HEIGHT_RST;
            en_release_reg <= 1'b1;
            en_drag_reg    <= 1'b1;
            en_move_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mpef_pkg::REG_SCREEN_WIDTH:  width_reg      <= cfg_data;
                mpef_pkg::REG_SCREEN_HEIGHT: height_reg     <= cfg_data;
                mpef_pkg::REG_EN_RELEASE:    en_release_reg <= cfg_data[0];
                mpef_pkg::REG_EN_DRAG:       en_drag_reg    <= cfg_data[0];
                mpef_pkg::REG_EN_MOVE:       en_move_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // new event from a report, and the filter (against the old buttons)
    always_comb
    begin
        new_ev.buttons = button_bits;
        new_ev.toggled = button_bits ^ prev_buttons_reg;
        new_ev.wheel   = wheel_delta;
        new_ev.pan     = pan_delta;
        new_ev.x       = mpef_pkg::clamp_pos(pos_x_reg, delta_x, width_reg);
        new_ev.y       = mpef_pkg::clamp_pos(pos_y_reg, delta_y, height_reg);

        queue_it = en_move_reg
            || ((button_bits & ~prev_buttons_reg) != '0)
            || (en_drag_reg && (button_bits != '0)
                && ((delta_x != '0) || (delta_y != '0)))
            || (en_release_reg && (button_bits != prev_buttons_reg))
            || (wheel_delta != '0) || (pan_delta != '0);
    end

    // queue pointers and next state
    always_comb
    begin
        head_inc = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        tail_sum = {1'b0, head_reg} + TAIL_W'(count_reg);
        if (tail_sum >= DEPTH_TAIL)
            tail_sum = tail_sum - DEPTH_TAIL;

        push              = is_report && queue_it;
        tail_ptr          = tail_sum[mpef_pkg::PTR_W-1:0];
        head_next         = head_reg;
        count_next        = count_reg;
        prev_buttons_next = prev_buttons_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;

        if (is_report)
        begin
            prev_buttons_next = button_bits;
            pos_x_next        = new_ev.x;
            pos_y_next        = new_ev.y;
            if (push)
            begin
                if (count_reg == FULL_CNT)
                begin
                    // drop the oldest: overwrite its slot and move the head on
                    tail_ptr  = head_reg;
                    head_next = head_inc;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
        else if (is_read && (count_reg != '0))
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
    end

    // read result: oldest event or state snapshot
    always_comb
    begin
        if (count_reg != '0)
        begin
            res.from_fifo = 1'b1;
            res.ev        = fifo_reg[head_reg];
        end
        else
        begin
            res.from_fifo  = 1'b0;
            res.ev.buttons = prev_buttons_reg;
            res.ev.toggled = '0;
            res.ev.wheel   = '0;
            res.ev.pan     = '0;
            res.ev.x       = pos_x_reg;
            res.ev.y       = pos_y_reg;
        end
        res.left = count_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_buttons_reg <= prev_buttons_next;
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || is_read;
                skid_valid_reg <= 1'b0;
            end
            else if (is_read)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload: queue storage, output and skid data
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[tail_ptr] <= new_ev;
        if (out_free)
        begin
            if (skid_valid_reg)
                out_res_reg <= skid_res_reg;
            else if (is_read)
                out_res_reg <= res;
        end
        else if (is_read)
        begin
            skid_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign from_fifo   = out_res_reg.from_fifo;
    assign ev_buttons  = out_res_reg.ev.buttons;
    assign ev_toggled  = out_res_reg.ev.toggled;
    assign ev_wheel    = out_res_reg.ev.wheel;
    assign ev_pan      = out_res_reg.ev.pan;
    assign ev_x        = out_res_reg.ev.x;
    assign ev_y        = out_res_reg.ev.y;
    assign events_left = out_res_reg.left;

    // checks
    `MPEF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_reg, "output valid after reset")
    `MPEF_ASSERT(a_count_in_range, count_reg <= FULL_CNT, "queue count beyond depth")
    `MPEF_ASSERT(a_head_in_range, head_reg <= LAST_PTR, "queue head beyond depth")
    `MPEF_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full, output empty")
    `MPEF_ASSERT(a_stalled_read_skids, (is_read && out_valid_reg && !out_ready) |=> skid_valid_reg, "stalled read lost")

endmodule

`default_nettype wire

@@ verif/mpef_event_checker.sv @@
// ----------------------------------------------------------------------------
// Mouse position event filter: scoreboard
// Watches the configuration, input and result channels, keeps its own copy of
// pointer, button and event queue state, and checks every result field by
// field against the oldest expected read.
// ----------------------------------------------------------------------------
module mpef_event_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration channel
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [mpef_pkg::IDX_W-1:0]          cfg_index,
    input  logic [mpef_pkg::DATA_W-1:0]         cfg_data,
    // input channel
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                func,
    input  logic [mpef_pkg::BTN_W-1:0]          button_bits,
    input  logic signed [mpef_pkg::DELTA_W-1:0] delta_x,
    input  logic signed [mpef_pkg::DELTA_W-1:0] delta_y,
    input  logic signed [mpef_pkg::WHL_W-1:0]   wheel_delta,
    input  logic signed [mpef_pkg::WHL_W-1:0]   pan_delta,
    // result channel
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                from_fifo,
    input  logic [mpef_pkg::BTN_W-1:0]          ev_buttons,
    input  logic [mpef_pkg::BTN_W-1:0]          ev_toggled,
    input  logic signed [mpef_pkg::WHL_W-1:0]   ev_wheel,
    input  logic signed [mpef_pkg::WHL_W-1:0]   ev_pan,
    input  logic [mpef_pkg::POS_W-1:0]          ev_x,
    input  logic [mpef_pkg::POS_W-1:0]          ev_y,
    input  logic [mpef_pkg::CNT_W-1:0]          events_left,
    // status for the testbench top
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  reports_seen,
    output int                                  reads_seen,
    output int                                  pops_seen,
    output int                                  drops_seen
);
    import mpef_pkg::*;

    // predicted block state
    ev_t              queued_events[$];
    res_t             expected_reads[$];
    logic [BTN_W-1:0] held_buttons;
    logic [POS_W-1:0] ptr_x;
    logic [POS_W-1:0] ptr_y;

    // predicted register contents
    logic [POS_W-1:0] width_reg;
    logic [POS_W-1:0] height_reg;
    logic             release_en;
    logic             drag_en;
    logic             move_en;

    // pointer axis: add the signed motion, then hold it inside 0 .. extent-1
    function automatic logic [POS_W-1:0] clamp_axis(
        input logic        [POS_W-1:0]   pos,
        input logic signed [DELTA_W-1:0] delta,
        input logic        [POS_W-1:0]   extent
    );
        int lim;
        int sum;
        lim = (extent == '0) ? 0 : int'(extent) - 1;  // zero size behaves as one
        sum = int'(pos) + int'(delta);
        if (sum < 0)
            sum = 0;
        if (sum > lim)
            sum = lim;
        return sum[POS_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // work out what an accepted item does to the state and what it returns
    task automatic predict_item();
        ev_t  ev;
        res_t res;
        logic queue_it;
        if (func == FUNC_REPORT)
        begin
            ev.buttons = button_bits;
            ev.toggled = button_bits ^ held_buttons;
            ev.wheel   = wheel_delta;
            ev.pan     = pan_delta;
            ev.x       = clamp_axis(ptr_x, delta_x, width_reg);
            ev.y       = clamp_axis(ptr_y, delta_y, height_reg);
            // all conditions look at the buttons from before this report
            queue_it = move_en
                    || ((button_bits & ~held_buttons) != '0)
                    || (drag_en && button_bits != '0 && (delta_x != 0 || delta_y != 0))
                    || (release_en && button_bits != held_buttons)
                    || wheel_delta != 0 || pan_delta != 0;
            held_buttons = button_bits;
            ptr_x        = ev.x;
            ptr_y        = ev.y;
            if (queue_it)
            begin
                // full queue loses its oldest entry
                if (queued_events.size() >= FIFO_DEPTH)
                begin
                    void'(queued_events.pop_front());
                    drops_seen++;
                end
                queued_events.push_back(ev);
            end
            reports_seen++;
        end
        else
        begin
            if (queued_events.size() != 0)
            begin
                res.from_fifo = 1'b1;
                res.ev        = queued_events.pop_front();
            end
            else
            begin
                // empty queue: snapshot of current state
                res.from_fifo  = 1'b0;
                res.ev.buttons = held_buttons;
                res.ev.toggled = '0;
                res.ev.wheel   = '0;
                res.ev.pan     = '0;
                res.ev.x       = ptr_x;
                res.ev.y       = ptr_y;
            end
            res.left = CNT_W'(queued_events.size());
            expected_reads.push_back(res);
        end
    endtask

    // compare one result transfer with the oldest expectation
    task automatic check_result();
        res_t want;
        if (expected_reads.size() == 0)
            report_mismatch("unexpected result", 1, 0);
        else
        begin
            want = expected_reads.pop_front();
            if (from_fifo !== want.from_fifo)
                report_mismatch("from_fifo", from_fifo, want.from_fifo);
            if (ev_buttons !== want.ev.buttons)
                report_mismatch("ev_buttons", ev_buttons, want.ev.buttons);
            if (ev_toggled !== want.ev.toggled)
                report_mismatch("ev_toggled", ev_toggled, want.ev.toggled);
            if (ev_wheel !== want.ev.wheel)
                report_mismatch("ev_wheel", ev_wheel, want.ev.wheel);
            if (ev_pan !== want.ev.pan)
                report_mismatch("ev_pan", ev_pan, want.ev.pan);
            if (ev_x !== want.ev.x)
                report_mismatch("ev_x", ev_x, want.ev.x);
            if (ev_y !== want.ev.y)
                report_mismatch("ev_y", ev_y, want.ev.y);
            if (events_left !== want.left)
                report_mismatch("events_left", events_left, want.left);
            if (want.from_fifo)
                pops_seen++;
            reads_seen++;
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_events.delete();
            expected_reads.delete();
            held_buttons = '0;
            ptr_x        = '0;
            ptr_y        = '0;
            width_reg    = SCREEN_WIDTH_RST;
            height_reg   = SCREEN_HEIGHT_RST;
            release_en   = 1'b1;
            drag_en      = 1'b1;
            move_en      = 1'b0;
            mismatches   = 0;
            outstanding  = 0;
            reports_seen = 0;
            reads_seen   = 0;
            pops_seen    = 0;
            drops_seen   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  = cfg_data[POS_W-1:0];
                    REG_SCREEN_HEIGHT: height_reg = cfg_data[POS_W-1:0];
                    REG_EN_RELEASE:    release_en = cfg_data[0];
                    REG_EN_DRAG:       drag_en    = cfg_data[0];
                    REG_EN_MOVE:       move_en    = cfg_data[0];
                    default:           ;
                endcase
            end
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_item();
            outstanding = expected_reads.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Mouse position event filter: testbench top
// Directed reports and reads, then random phases under a range of screen
// sizes and filter enables, with bursty input, receiver stalls, one long
// receiver hold-off and drains between phases. Checking is in the scoreboard.
// ----------------------------------------------------------------------------
module tb;
    import mpef_pkg::*;

    localparam int HOLD_CYCLES   = 64;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 70;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_valid   = 1'b0;
    logic                        cfg_ready;
    logic [IDX_W-1:0]            cfg_index   = '0;
    logic [DATA_W-1:0]           cfg_data    = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic                        func        = FUNC_REPORT;
    logic [BTN_W-1:0]            button_bits = '0;
    logic signed [DELTA_W-1:0]   delta_x     = '0;
    logic signed [DELTA_W-1:0]   delta_y     = '0;
    logic signed [WHL_W-1:0]     wheel_delta = '0;
    logic signed [WHL_W-1:0]     pan_delta   = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic                        from_fifo;
    logic [BTN_W-1:0]            ev_buttons;
    logic [BTN_W-1:0]            ev_toggled;
    logic signed [WHL_W-1:0]     ev_wheel;
    logic signed [WHL_W-1:0]     ev_pan;
    logic [POS_W-1:0]            ev_x;
    logic [POS_W-1:0]            ev_y;
    logic [CNT_W-1:0]            events_left;

    int mismatches;
    int outstanding;
    int reports_seen;
    int reads_seen;
    int pops_seen;
    int drops_seen;

    // stimulus bookkeeping
    int               burst_left;
    int               settings_done;
    int               idle_cycles;
    logic             hold_req;
    logic [BTN_W-1:0] last_buttons;
    logic [7:0]       ready_pattern;
    int               pattern_age;

    mouse_position_event_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .button_bits (button_bits),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .wheel_delta (wheel_delta),
        .pan_delta   (pan_delta),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .from_fifo   (from_fifo),
        .ev_buttons  (ev_buttons),
        .ev_toggled  (ev_toggled),
        .ev_wheel    (ev_wheel),
        .ev_pan      (ev_pan),
        .ev_x        (ev_x),
        .ev_y        (ev_y),
        .events_left (events_left)
    );

    mpef_event_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .button_bits  (button_bits),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .wheel_delta  (wheel_delta),
        .pan_delta    (pan_delta),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .from_fifo    (from_fifo),
        .ev_buttons   (ev_buttons),
        .ev_toggled   (ev_toggled),
        .ev_wheel     (ev_wheel),
        .ev_pan       (ev_pan),
        .ev_x         (ev_x),
        .ev_y         (ev_y),
        .events_left  (events_left),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .reports_seen (reports_seen),
        .reads_seen   (reads_seen),
        .pops_seen    (pops_seen),
        .drops_seen   (drops_seen)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("[mouse_position_event_filter] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result receiver: rotating stall pattern, or a long hold-off on request
    initial
    begin
        hold_req      = 1'b0;
        ready_pattern = 8'hFF;
        pattern_age   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (pattern_age == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       ready_pattern = 8'hFF;
                        1:       ready_pattern = 8'hAA;
                        2:       ready_pattern = 8'h0F;
                        default: ready_pattern = 8'($urandom) | 8'h01;
                    endcase
                    pattern_age = $urandom_range(20, 60);
                end
                pattern_age--;
                out_ready     <= ready_pattern[0];
                ready_pattern  = {ready_pattern[0], ready_pattern[7:1]};
            end
        end
    end

    // one input transfer; valid stays high on return
    task automatic push_item(
        input logic                      f,
        input logic [BTN_W-1:0]          b,
        input logic signed [DELTA_W-1:0] dx,
        input logic signed [DELTA_W-1:0] dy,
        input logic signed [WHL_W-1:0]   wh,
        input logic signed [WHL_W-1:0]   pn
    );
        in_valid    <= 1'b1;
        func        <= f;
        button_bits <= b;
        delta_x     <= dx;
        delta_y     <= dy;
        wheel_delta <= wh;
        pan_delta   <= pn;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // bursty sender: random gap before each burst
    task automatic offer(
        input logic                      f,
        input logic [BTN_W-1:0]          b,
        input logic signed [DELTA_W-1:0] dx,
        input logic signed [DELTA_W-1:0] dy,
        input logic signed [WHL_W-1:0]   wh,
        input logic signed [WHL_W-1:0]   pn
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push_item(f, b, dx, dy, wh, pn);
    endtask

    // stop sending and wait for every expected read to come back
    task automatic quiesce();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_settings(
        input logic [POS_W-1:0] w,
        input logic [POS_W-1:0] h,
        input logic             rel,
        input logic             drag,
        input logic             move
    );
        cfg_write(REG_SCREEN_WIDTH, DATA_W'(w));
        cfg_write(REG_SCREEN_HEIGHT, DATA_W'(h));
        cfg_write(REG_EN_RELEASE, DATA_W'(rel));
        cfg_write(REG_EN_DRAG, DATA_W'(drag));
        cfg_write(REG_EN_MOVE, DATA_W'(move));
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // motion: mostly none or small, sometimes extreme or full range
    function automatic logic signed [DELTA_W-1:0] pick_delta();
        int sel;
        int small_step;
        sel = $urandom_range(0, 9);
        small_step = int'($urandom_range(0, 40)) - 20;
        if (sel < 3)
            return '0;
        else if (sel < 7)
            return DELTA_W'(small_step);
        else if (sel == 7)
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        else
            return DELTA_W'($urandom);
    endfunction

    function automatic logic signed [WHL_W-1:0] pick_wheel();
        if ($urandom_range(0, 9) < 7)
            return '0;
        else
            return WHL_W'($urandom);
    endfunction

    // report that mostly continues a press / drag / release gesture
    task automatic random_report();
        logic [BTN_W-1:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: b = last_buttons;
            4, 5:       b = '0;
            6, 7:       b = last_buttons ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
            default:    b = BTN_W'($urandom);
        endcase
        last_buttons = b;
        offer(FUNC_REPORT, b, pick_delta(), pick_delta(), pick_wheel(), pick_wheel());
    endtask

    task automatic random_read();
        offer(FUNC_READ, BTN_W'($urandom), DELTA_W'($urandom), DELTA_W'($urandom),
              WHL_W'($urandom), WHL_W'($urandom));
    endtask

    // stimulus
    initial
    begin
        logic [POS_W-1:0] w;
        logic [POS_W-1:0] h;
        logic [2:0]       flags;
        int               read_pct;

        burst_left    = 0;
        settings_done = 0;
        last_buttons  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: 320 x 240, release and drag on, move off
        offer(FUNC_READ,   8'h00, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);  // empty snapshot
        offer(FUNC_REPORT, 8'h01, 16'sh8000, 16'sh8000, 8'sh00, 8'sh00);  // press, clamp low
        offer(FUNC_REPORT, 8'h01, 16'sh7FFF, 16'sh7FFF, 8'sh00, 8'sh00);  // drag, clamp high
        offer(FUNC_REPORT, 8'h00, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);  // release
        offer(FUNC_REPORT, 8'h00, 16'sh0000, 16'sh0000, 8'sh80, 8'sh7F);  // wheel and pan
        offer(FUNC_REPORT, 8'h00, -16'sd5,   16'sd3,    8'sh7F, 8'sh80);  // overflow, drop oldest
        offer(FUNC_REPORT, 8'h00, 16'sd10,   16'sd10,   8'sh00, 8'sh00);  // plain move, filtered
        offer(FUNC_REPORT, 8'hFF, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);  // all pressed
        offer(FUNC_REPORT, 8'hFF, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);  // held, no motion
        offer(FUNC_REPORT, 8'h80, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);  // partial release
        repeat (6)
            offer(FUNC_READ, 8'hFF, 16'shFFFF, 16'shFFFF, 8'shFF, 8'shFF);
        offer(FUNC_REPORT, 8'h80, -16'sd1,   16'sh0000, 8'sh00, 8'sh00);  // drag, one step
        offer(FUNC_REPORT, 8'h00, 16'sh0000, 16'sh0000, 8'sh00, 8'sh01);  // release with pan
        offer(FUNC_READ,   8'h00, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);
        offer(FUNC_READ,   8'h00, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);
        offer(FUNC_READ,   8'h00, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00);

        // random phases, each under its own register settings
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin w = 15'd1;     h = 15'd1;     flags = 3'b001; end
                1: begin w = 15'd32767; h = 15'd32767; flags = 3'b110; end
                2: begin w = 15'd0;     h = 15'd0;     flags = 3'b100; end
                3: begin w = 15'd320;   h = 15'd240;   flags = 3'b010; end
                4: begin
                    w = POS_W'($urandom_range(1, 64));
                    h = POS_W'($urandom_range(1, 64));
                    flags = 3'($urandom);
                end
                5: begin
                    w = POS_W'($urandom_range(1, 32767));
                    h = POS_W'($urandom_range(1, 32767));
                    flags = 3'($urandom);
                end
                6: begin w = 15'd16;    h = 15'd8;     flags = 3'b111; end
                7: begin
                    w = POS_W'($urandom_range(1, 8));
                    h = POS_W'($urandom_range(1, 8));
                    flags = 3'b000;
                end
                default: begin w = 15'd320; h = 15'd240; flags = 3'b110; end
            endcase
            quiesce();
            apply_settings(w, h, flags[2], flags[1], flags[0]);

            // receiver holds off while reads keep coming, so the block backs up
            if (p == 1)
            begin
                repeat (8)
                    push_item(FUNC_REPORT, BTN_W'($urandom), pick_delta(), pick_delta(),
                              8'sh01, pick_wheel());
                hold_req = 1'b1;
                repeat (24)
                    push_item(FUNC_READ, BTN_W'($urandom), DELTA_W'($urandom),
                              DELTA_W'($urandom), WHL_W'($urandom), WHL_W'($urandom));
            end

            read_pct = $urandom_range(15, 60);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(1, 100) <= read_pct)
                    random_read();
                else
                    random_report();
            end
        end

        quiesce();
        $display("run covered %0d reports and %0d reads (%0d queued events, %0d snapshots),",
                 reports_seen, reads_seen, pops_seen, reads_seen - pops_seen);
        $display("%0d queue overflows, %0d register settings, one long receiver hold-off",
                 drops_seen, settings_done);
        if (mismatches == 0 && outstanding == 0)
            $display("[mouse_position_event_filter] OK");
        else
            $display("[mouse_position_event_filter] ERROR");
        $finish;
    end

endmodule
